// ===== hdl/region_access_checker_assert.svh =====
// assertion helpers for the region access checker
`ifndef REGION_ACCESS_CHECKER_ASSERT_SVH
`define REGION_ACCESS_CHECKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("region access checker assertion failed");

// next-cycle implication, checked out of reset
`define RAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("region access checker assertion failed");

`endif

// ===== hdl/rac_pkg.sv =====
`timescale 1ns / 1ps

package rac_pkg;

    localparam int unsigned RAC_SLOTS_DEFAULT = 16;
    localparam int unsigned RAC_AW            = 64;

    // operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ARGS  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NO_REGION = 3'd3;
    localparam logic [2:0] ST_DENIED    = 3'd4;
    localparam logic [2:0] ST_NO_BUFFER = 3'd5;

    // one table entry as held in the region ram
    typedef struct packed {
        logic [RAC_AW-1:0] base;
        logic [RAC_AW-1:0] size;
        logic              readable;
        logic              writable;
    } t_entry;

    localparam int unsigned RAC_ENTRY_W = $bits(t_entry);

    // outcome of testing one entry against the access span
    typedef struct packed {
        logic hit;
        logic allowed;
    } t_match;

endpackage

// ===== hdl/region_access_checker.sv =====
`timescale 1ns / 1ps

// Region access checker: holds a table of up to REGION_SLOTS address regions
// (base, size, read and write permission) in one single-port-read ram, plus a
// region count and a running byte total. Every input transfer yields exactly one
// output transfer. An add passes through S_ADD and S_DONE to the result register,
// a clear goes straight to S_DONE, and a read or write check scans in S_SCAN
// before S_DONE, examining from one entry up to the current region count (so at
// most REGION_SLOTS): the first match search reads one entry per cycle through
// the ram read port. A check on an empty table skips the scan. One item is in
// flight at a time; the result register lets the next item be taken while the
// previous result waits. No clearing pass is needed after reset: only entries below
// the region count are ever tested, so the table ram itself is never initialized.
module region_access_checker
    import rac_pkg::*;
#(
    parameter int unsigned REGION_SLOTS = RAC_SLOTS_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,  // address[63:0], length[127:64], may_read[128],
                                     // may_write[129], buffer_present[130], zero pad
    input  logic [1:0]   i_s_tuser,  // op[1:0]
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [79:0]  o_m_tdata   // ok[0], status[3:1], region_total[8:4],
                                     // byte_total[72:9], zero pad
);

`include "region_access_checker_assert.svh"

    localparam int unsigned AW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int unsigned CW = $clog2(REGION_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [RAC_AW-1:0] r_addr, n_addr;
    logic [RAC_AW-1:0] r_len, n_len;
    logic              r_rd, n_rd;
    logic              r_wr, n_wr;
    logic              r_buf, n_buf;
    logic [RAC_AW:0]   r_end, n_end;    // access end, 65 bits
    logic [AW-1:0]     r_idx, n_idx;    // entry whose ram data is on the read port
    logic [CW-1:0]     r_count, n_count;
    logic [RAC_AW-1:0] r_sum, n_sum;
    logic [2:0]        r_status, n_status;
    logic              r_m_tvalid, n_m_tvalid;
    logic [79:0]       r_m_tdata, n_m_tdata;

    logic              w_s_xfer;
    logic [CW-1:0]     w_idx_next;
    logic [AW-1:0]     w_raddr;
    logic              w_we;
    t_entry            w_wentry;
    t_entry            w_rentry;
    t_match            w_match;
    logic [RAC_AW:0]   w_base_end;
    logic [RAC_AW:0]   w_sum_end;
    logic              w_bad;
    logic              w_full;
    logic [CW+4:0]     w_count_ext;
    logic [RAC_ENTRY_W-1:0] w_rdata;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_xfer   = i_s_tvalid && o_s_tready;

    // scan walks the table in insertion order; the ram read for the next entry
    // is issued while the current one is tested, so one entry per cycle
    assign w_idx_next = CW'(r_idx) + CW'(1);
    assign w_raddr    = (r_state == S_SCAN) ? w_idx_next[AW-1:0] : '0;

    // table writes only happen in the add step, never while a scan reads, so
    // no forwarding between the write and read side is needed
    assign w_wentry.base     = r_addr;
    assign w_wentry.size     = r_len;
    assign w_wentry.readable = r_rd;
    assign w_wentry.writable = r_wr;

    // add argument tests: zero fields, region end at or past 2^64, byte total overflow
    assign w_base_end = {1'b0, r_addr} + {1'b0, r_len};
    assign w_sum_end  = {1'b0, r_sum} + {1'b0, r_len};
    assign w_bad      = (r_addr == '0) || (r_len == '0) ||
                        w_base_end[RAC_AW] || w_sum_end[RAC_AW];
    assign w_full     = (r_count == CW'(REGION_SLOTS));
    assign w_we       = (r_state == S_ADD) && !w_bad && !w_full;

    rac_ram #(
        .WIDTH (RAC_ENTRY_W),
        .DEPTH (REGION_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wentry),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rentry = t_entry'(w_rdata);

    rac_match u_match (
        .i_entry    (w_rentry),
        .i_start    (r_addr),
        .i_end      (r_end),
        .i_is_write (r_op == OP_WRITE),
        .o_res      (w_match)
    );

    // region_total is the low five bits of the count
    assign w_count_ext = {5'b0, r_count};

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_addr     = r_addr;
        n_len      = r_len;
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_buf      = r_buf;
        n_end      = r_end;
        n_idx      = r_idx;
        n_count    = r_count;
        n_sum      = r_sum;
        n_status   = r_status;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_tdata  = r_m_tdata;

        case (r_state)
            S_IDLE: begin
                if (w_s_xfer) begin
                    n_op   = i_s_tuser;
                    n_addr = i_s_tdata[63:0];
                    n_len  = i_s_tdata[127:64];
                    n_rd   = i_s_tdata[128];
                    n_wr   = i_s_tdata[129];
                    n_buf  = i_s_tdata[130];
                    n_end  = {1'b0, i_s_tdata[63:0]} + {1'b0, i_s_tdata[127:64]};
                    n_idx  = '0;
                    case (i_s_tuser)
                        OP_ADD: begin
                            n_state = S_ADD;
                        end
                        OP_READ, OP_WRITE: begin
                            if (r_count == '0) begin
                                n_status = ST_NO_REGION;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // clear table
                            n_count  = '0;
                            n_sum    = '0;
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (w_bad) begin
                    n_status = ST_BAD_ARGS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count + CW'(1);
                    n_sum    = w_sum_end[RAC_AW-1:0];
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (w_match.hit) begin
                    // only the first matching region decides
                    if (!w_match.allowed) begin
                        n_status = ST_DENIED;
                    end else if (!r_buf) begin
                        n_status = ST_NO_BUFFER;
                    end else begin
                        n_status = ST_OK;
                    end
                    n_state = S_DONE;
                end else if (w_idx_next == r_count) begin
                    n_status = ST_NO_REGION;
                    n_state  = S_DONE;
                end else begin
                    n_idx = w_idx_next[AW-1:0];
                end
            end
            S_DONE: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {7'b0, r_sum, w_count_ext[4:0], r_status,
                                  (r_status == ST_OK)};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_sum      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_m_tvalid <= n_m_tvalid;
        end
        r_op      <= n_op;
        r_addr    <= n_addr;
        r_len     <= n_len;
        r_rd      <= n_rd;
        r_wr      <= n_wr;
        r_buf     <= n_buf;
        r_end     <= n_end;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_m_tdata <= n_m_tdata;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // region count never passes table capacity
    `RAC_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(REGION_SLOTS))
    // a table write always lands in a free slot
    `RAC_ASSERT_NOW(a_write_free, i_clk, i_rst_n, w_we, r_count < CW'(REGION_SLOTS))
    // one item in flight: after a transfer in, no further transfer is taken
    `RAC_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_s_xfer, !o_s_tready)
    // scan only looks at held entries
    `RAC_ASSERT_NOW(a_scan_held, i_clk, i_rst_n, r_state == S_SCAN, CW'(r_idx) < r_count)
    // a clear empties count and byte total
    `RAC_ASSERT_NEXT(a_clear, i_clk, i_rst_n, w_s_xfer && (i_s_tuser == OP_CLEAR),
                     (r_count == '0) && (r_sum == '0))

endmodule

// ===== hdl/rac_ram.sv =====
`timescale 1ns / 1ps

module rac_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rac_match.sv =====
`timescale 1ns / 1ps

module rac_match
    import rac_pkg::*;
(
    input  t_entry            i_entry,
    input  logic [RAC_AW-1:0] i_start,
    input  logic [RAC_AW:0]   i_end,
    input  logic              i_is_write,
    output t_match            o_res
);

    // region limit one past its last byte, kept at 65 bits so it cannot wrap
    logic [RAC_AW:0] w_limit;

    assign w_limit = {1'b0, i_entry.base} + {1'b0, i_entry.size};

    // span inside region: start at or above base, start and end at or below limit
    assign o_res.hit = (i_start >= i_entry.base) &&
                       ({1'b0, i_start} <= w_limit) &&
                       (i_end <= w_limit);
    assign o_res.allowed = i_is_write ? i_entry.writable : i_entry.readable;

endmodule

// ===== tb/sv/tb_region_access_checker.sv =====
`timescale 1ns / 1ps

module tb_region_access_checker;
    import rac_pkg::*;

    localparam int unsigned SLOTS      = RAC_SLOTS_DEFAULT;
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam int unsigned RANDOM_REQ = 950;
    localparam int unsigned TAIL_WAIT  = 60;

    // one result transfer, split into its fields
    typedef struct {
        logic        ok;
        logic [2:0]  status;
        logic [4:0]  regions;
        logic [63:0] bytes;
    } t_verdict;

    // mirror of the region table plus the queue of verdicts still owed by the block
    class region_verdict_board;
        logic [63:0] held_base[SLOTS];
        logic [63:0] held_size[SLOTS];
        logic        held_readable[SLOTS];
        logic        held_writable[SLOTS];
        int unsigned held_count;
        logic [63:0] held_bytes;
        t_verdict    pending_verdicts[$];
        int unsigned mismatches;
        int unsigned ops_seen[4];
        int unsigned status_seen[8];

        function new();
            held_count = 0;
            held_bytes = '0;
            mismatches = 0;
            foreach (ops_seen[i]) ops_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // apply one accepted request to the mirror and queue the verdict it must give
        function void note_request(logic [1:0] op, logic [63:0] addr, logic [63:0] cnt,
                                   logic rd, logic wr, logic has_buffer);
            t_verdict    v;
            logic [63:0] off;
            logic [2:0]  st;
            int          hit;
            hit = -1;
            st  = ST_OK;
            case (op)
                OP_ADD: begin
                    // argument tests win over the capacity test
                    if (addr == 0 || cnt == 0 || cnt > ~addr || cnt > ~held_bytes) begin
                        st = ST_BAD_ARGS;
                    end else if (held_count >= SLOTS) begin
                        st = ST_FULL;
                    end else begin
                        held_base[held_count]     = addr;
                        held_size[held_count]     = cnt;
                        held_readable[held_count] = rd;
                        held_writable[held_count] = wr;
                        held_count++;
                        held_bytes += cnt;
                    end
                end
                OP_READ, OP_WRITE: begin
                    // first region in insertion order that holds the whole span
                    for (int k = 0; k < held_count; k++) begin
                        if (hit < 0 && addr >= held_base[k]) begin
                            off = addr - held_base[k];
                            if (off <= held_size[k] && cnt <= held_size[k] - off) hit = k;
                        end
                    end
                    if (hit < 0)
                        st = ST_NO_REGION;
                    else if (op == OP_WRITE ? !held_writable[hit] : !held_readable[hit])
                        st = ST_DENIED;
                    else if (!has_buffer)
                        st = ST_NO_BUFFER;
                end
                default: begin
                    held_count = 0;
                    held_bytes = '0;
                end
            endcase
            v.ok      = (st == ST_OK);
            v.status  = st;
            v.regions = 5'(held_count);
            v.bytes   = held_bytes;
            pending_verdicts = {pending_verdicts, v};
            ops_seen[op]++;
        endfunction

        task report_mismatch(string what, logic [79:0] got, logic [79:0] want);
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
            mismatches++;
        endtask

        // compare one result transfer with the oldest pending verdict
        task check_verdict(logic [79:0] word);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result transfer with nothing pending", word, '0);
                return;
            end
            want = pending_verdicts.pop_front();
            status_seen[want.status]++;
            if (word[0] !== want.ok)
                report_mismatch("ok", word[0], want.ok);
            if (word[3:1] !== want.status)
                report_mismatch("status", word[3:1], want.status);
            if (word[8:4] !== want.regions)
                report_mismatch("region_total", word[8:4], want.regions);
            if (word[72:9] !== want.bytes)
                report_mismatch("byte_total", word[72:9], want.bytes);
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [135:0] i_s_tdata;   // address[63:0], length[127:64], may_read[128],
                               // may_write[129], buffer_present[130], zero pad
    logic [1:0]   i_s_tuser;   // op[1:0]
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [79:0]  o_m_tdata;   // ok[0], status[3:1], region_total[8:4],
                               // byte_total[72:9], zero pad

    region_verdict_board board;
    int unsigned         cycle_count;
    int unsigned         burst_left;
    int unsigned         random_sent;
    int unsigned         stall_mode;
    int unsigned         stall_phase_left;
    int unsigned         stall_tick;

    region_access_checker #(
        .REGION_SLOTS (SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run guard: ends the run as failed once cycle_count reaches CYCLE_CAP
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("timeout with %0d verdicts pending", board.pending_verdicts.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver side: stall pattern picks a new random mode after each random-length phase
    // mode 0 never stalls, 1 coin flip, 2 sparse ready pulses, 3 long stalls
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_phase_left == 0) begin
            stall_mode       <= $urandom_range(0, 3);
            stall_phase_left <= $urandom_range(40, 300);
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= (stall_tick % 6 == 0);
            default: i_m_tready <= (stall_tick % 32 >= 24);
        endcase
    end

    // result side: every accepted result transfer is checked at the edge it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_verdict(o_m_tdata);
    end

    function automatic logic [63:0] wide_rand();
        return {$urandom, $urandom};
    endfunction

    // uniform-ish value in 0..limit over the full 64-bit range
    function automatic logic [63:0] rand_upto(logic [63:0] limit);
        if (limit == ~64'd0) return wide_rand();
        return wide_rand() % (limit + 64'd1);
    endfunction

    // one input transfer; the sender may idle between bursts of random length
    task automatic send_request(logic [1:0] op, logic [63:0] addr, logic [63:0] cnt,
                                logic rd, logic wr, logic has_buffer);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {5'b0, has_buffer, wr, rd, cnt, addr};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_request(op, addr, cnt, rd, wr, has_buffer);
    endtask

    // hold off the sender until the block owes nothing
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // random add: mostly well-formed regions clustered low so checks can hit them
    task automatic send_random_add();
        logic [63:0] addr;
        logic [63:0] cnt;
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            cnt  = 64'($urandom_range(1, 4096));
            addr = ($urandom_range(0, 1) == 1) ?
                   64'h1000 * $urandom_range(1, 64) + $urandom_range(0, 255) : wide_rand();
            if (addr == 0) addr = 64'd1;
            if (cnt > ~addr) addr = ~cnt;
        end else if (pick < 65 && board.held_count != 0) begin
            // overlap an existing region so first-match shadowing comes up
            k    = $urandom_range(0, board.held_count - 1);
            addr = board.held_base[k];
            cnt  = rand_upto(board.held_size[k]) << $urandom_range(0, 1);
            if (cnt == 0) cnt = 64'd1;
        end else if (pick < 75) begin
            addr = 64'($urandom_range(1, 1 << 20));
            cnt  = wide_rand();
        end else if (pick < 85) begin
            addr = ($urandom_range(0, 1) == 1) ? 64'd0 : wide_rand();
            cnt  = (addr == 0) ? 64'($urandom_range(0, 64)) : 64'd0;
        end else if (pick < 93) begin
            addr = ~64'($urandom_range(0, 255));
            cnt  = 64'($urandom_range(1, 512));
        end else begin
            addr = wide_rand();
            cnt  = wide_rand();
        end
        send_request(OP_ADD, addr, cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    endtask

    // random check: spans inside a held region, just outside one, or anywhere
    task automatic send_random_check();
        logic [63:0] addr;
        logic [63:0] cnt;
        logic [63:0] off;
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(0, 99);
        if (board.held_count != 0 && pick < 60) begin
            k   = $urandom_range(0, board.held_count - 1);
            off = ($urandom_range(0, 9) == 0) ? board.held_size[k]
                                               : rand_upto(board.held_size[k]);
            cnt = ($urandom_range(0, 4) == 0) ? board.held_size[k] - off
                                               : rand_upto(board.held_size[k] - off);
            addr = board.held_base[k] + off;
        end else if (board.held_count != 0 && pick < 78) begin
            k = $urandom_range(0, board.held_count - 1);
            if ($urandom_range(0, 1) == 1 && board.held_size[k] != ~64'd0) begin
                addr = board.held_base[k];
                cnt  = board.held_size[k] + 64'd1;
            end else begin
                addr = board.held_base[k] - 64'd1;
                cnt  = 64'($urandom_range(0, 8));
            end
        end else begin
            addr = wide_rand();
            cnt  = ($urandom_range(0, 1) == 1) ? wide_rand() : 64'($urandom_range(0, 64));
        end
        send_request(($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ, addr, cnt,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 6) != 0));
    endtask

    initial begin
        int unsigned episode_len;
        int unsigned add_share;
        board            = new();
        burst_left       = 0;
        random_sent      = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= OP_ADD;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, argument errors, extremes of the address space
        send_request(OP_READ,  64'h1000, 64'd1, 1'b0, 1'b0, 1'b1);
        send_request(OP_CLEAR, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0);
        send_request(OP_ADD,   64'd0, 64'd16, 1'b1, 1'b1, 1'b0);
        send_request(OP_ADD,   64'h1000, 64'd0, 1'b1, 1'b1, 1'b0);
        send_request(OP_ADD,   ~64'd0, 64'd1, 1'b1, 1'b1, 1'b0);
        // region ending one byte below the top of the space, read-only
        send_request(OP_ADD,   64'd1, ~64'd1, 1'b1, 1'b0, 1'b0);
        // byte total would wrap, then lands exactly on all ones
        send_request(OP_ADD,   64'h10, 64'd2, 1'b0, 1'b1, 1'b0);
        send_request(OP_ADD,   64'h10, 64'd1, 1'b0, 1'b1, 1'b0);
        // zero-length span at the very end of a region
        send_request(OP_READ,  ~64'd0, 64'd0, 1'b0, 1'b0, 1'b1);
        send_request(OP_READ,  64'd1, ~64'd1, 1'b0, 1'b0, 1'b0);
        // later writable region is never consulted
        send_request(OP_WRITE, 64'h10, 64'd1, 1'b0, 1'b0, 1'b1);
        send_request(OP_READ,  64'd0, 64'd0, 1'b0, 1'b0, 1'b1);
        send_request(OP_READ,  64'd1, ~64'd0, 1'b0, 1'b0, 1'b1);
        send_request(OP_CLEAR, ~64'd0, ~64'd0, 1'b1, 1'b1, 1'b1);
        send_request(OP_ADD,   64'h2000, 64'h100, 1'b0, 1'b1, 1'b0);
        send_request(OP_ADD,   64'h2000, 64'h200, 1'b1, 1'b1, 1'b0);
        send_request(OP_READ,  64'h2000, 64'h100, 1'b0, 1'b0, 1'b1);
        send_request(OP_READ,  64'h2100, 64'h100, 1'b0, 1'b0, 1'b1);
        send_request(OP_WRITE, 64'h20ff, 64'd1, 1'b0, 1'b0, 1'b0);
        send_request(OP_WRITE, 64'h2100, 64'd0, 1'b0, 1'b0, 1'b1);
        send_request(OP_READ,  64'h2200, 64'd0, 1'b0, 1'b0, 1'b1);
        send_request(OP_READ,  64'h2200, 64'd1, 1'b0, 1'b0, 1'b1);
        wait_drained();

        // random episodes: each opens with a clear, some add enough to fill the table
        while (random_sent < RANDOM_REQ) begin
            if ($urandom_range(0, 3) == 0) wait_drained();
            send_request(OP_CLEAR, wide_rand(), wide_rand(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            random_sent++;
            episode_len = $urandom_range(5, 60);
            add_share   = $urandom_range(20, 80);
            repeat (episode_len) begin
                if ($urandom_range(0, 99) < add_share) send_random_add();
                else send_random_check();
                random_sent++;
            end
        end

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("run covered %0d transfers: %0d adds, %0d reads, %0d writes, %0d clears",
                 board.ops_seen[OP_ADD] + board.ops_seen[OP_READ] + board.ops_seen[OP_WRITE]
                 + board.ops_seen[OP_CLEAR], board.ops_seen[OP_ADD], board.ops_seen[OP_READ],
                 board.ops_seen[OP_WRITE], board.ops_seen[OP_CLEAR]);
        $display("outcomes: ok %0d, bad args %0d, full %0d, no region %0d, denied %0d, no buffer %0d",
                 board.status_seen[ST_OK], board.status_seen[ST_BAD_ARGS],
                 board.status_seen[ST_FULL], board.status_seen[ST_NO_REGION],
                 board.status_seen[ST_DENIED], board.status_seen[ST_NO_BUFFER]);
        if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
